// File: design/rrtl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrtl_pkg: shared types and constants of the round-robin task run list
// Operation, status and slot mark codes, and the command word that the
// controller broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package rrtl_pkg;

  localparam int unsigned DEFAULT_SLOT_COUNT = 16;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned TSLOT_W  = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_RUN   = 2'd1,
    OP_TICK  = 2'd2,
    OP_SLEEP = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MARK_FREE     = 2'd0,
    MARK_SLEEPING = 2'd1,
    MARK_ACTIVE   = 2'd2
  } mark_e;

  // What a cell offers to the search lane
  typedef enum logic [1:0] {
    SEL_FREE   = 2'd0,  // slot is free
    SEL_ACTIVE = 2'd1,  // cell is the keyed slot and it is active
    SEL_POS    = 2'd2,  // cell is the keyed list position
    SEL_ENTRY  = 2'd3   // list entry inside the run count holds the keyed slot
  } sel_e;

  typedef struct packed {
    sel_e  sel;
    logic  wr_mark;
    mark_e mark_val;
    logic  wr_entry;
    logic  shift;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: design/rrtl_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrtl_in_if: operation channel
// Valid/ready channel carrying one scheduler operation per word.
// ----------------------------------------------------------------------------
interface rrtl_in_if;
  logic                             valid;
  logic                             ready;
  logic [rrtl_pkg::OP_W-1:0]        operation;
  logic [rrtl_pkg::TSLOT_W-1:0]     task_slot;

  modport source (output valid, output operation, output task_slot, input ready);
  modport sink   (input valid, input operation, input task_slot, output ready);
endinterface
`default_nettype wire

// File: design/rrtl_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrtl_out_if: result channel
// Valid/ready channel carrying one scheduler result per word.
// ----------------------------------------------------------------------------
interface rrtl_out_if;
  logic                             valid;
  logic                             ready;
  logic [rrtl_pkg::STATUS_W-1:0]    status;
  logic [rrtl_pkg::SLOT_W-1:0]      slot;
  logic                             jump;
  logic [rrtl_pkg::COUNT_W-1:0]     running_count;

  modport source (output valid, output status, output slot, output jump,
                  output running_count, input ready);
  modport sink   (input valid, input status, input slot, input jump,
                  input running_count, output ready);
endinterface
`default_nettype wire

// File: design/rrtl_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrtl_cell: one slot of the run list chain
// Holds the mark of slot CELL_INDEX and run list entry CELL_INDEX, takes
// the entry of its upper neighbour on a shift, and forwards the search lane.
// ----------------------------------------------------------------------------
module rrtl_cell #(
  parameter int unsigned SLOT_COUNT = rrtl_pkg::DEFAULT_SLOT_COUNT,
  parameter int unsigned CELL_INDEX = 0
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire rrtl_pkg::cell_ctrl_t          ctrl_i,
  input  wire logic [$clog2(SLOT_COUNT)-1:0] slot_key_i,
  input  wire logic [$clog2(SLOT_COUNT)-1:0] pos_key_i,
  input  wire logic [$clog2(SLOT_COUNT+1)-1:0] total_i,
  input  wire logic [$clog2(SLOT_COUNT)-1:0] next_entry_i,
  output logic      [$clog2(SLOT_COUNT)-1:0] entry_o,
  input  wire logic                          lane_hit_i,
  input  wire logic [$clog2(SLOT_COUNT)-1:0] lane_idx_i,
  input  wire logic [$clog2(SLOT_COUNT)-1:0] lane_data_i,
  output logic                               lane_hit_o,
  output logic      [$clog2(SLOT_COUNT)-1:0] lane_idx_o,
  output logic      [$clog2(SLOT_COUNT)-1:0] lane_data_o
);

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);
  localparam logic [CNT_W-1:0] MY_POS = CNT_W'(CELL_INDEX);
  localparam rrtl_pkg::mark_e RESET_MARK =
    (CELL_INDEX == 0) ? rrtl_pkg::MARK_ACTIVE : rrtl_pkg::MARK_FREE;

  rrtl_pkg::mark_e  mark_q, mark_d;
  logic [IDX_W-1:0] entry_q, entry_d;
  logic             hit_q;
  logic [IDX_W-1:0] idx_q, data_q;
  logic             sel;

  always_comb begin
    unique case (ctrl_i.sel)
      rrtl_pkg::SEL_FREE:   sel = (mark_q == rrtl_pkg::MARK_FREE);
      rrtl_pkg::SEL_ACTIVE: sel = (slot_key_i == MY_IDX) && (mark_q == rrtl_pkg::MARK_ACTIVE);
      rrtl_pkg::SEL_POS:    sel = (pos_key_i == MY_IDX);
      rrtl_pkg::SEL_ENTRY:  sel = (MY_POS < total_i) && (entry_q == slot_key_i);
      default:              sel = 1'b0;
    endcase
  end

  always_comb begin
    mark_d  = mark_q;
    entry_d = entry_q;
    if (ctrl_i.wr_mark && (slot_key_i == MY_IDX)) begin
      mark_d = ctrl_i.mark_val;
    end
    // close the gap: every entry at or above the removed one moves down
    if (ctrl_i.shift && (MY_IDX >= pos_key_i)) begin
      entry_d = next_entry_i;
    end else if (ctrl_i.wr_entry && (pos_key_i == MY_IDX)) begin
      entry_d = slot_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q  <= RESET_MARK;
      entry_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      mark_q  <= mark_d;
      entry_q <= entry_d;
      hit_q   <= lane_hit_i || sel;
    end
  end

  // lowest selecting cell wins: a word that already hit passes untouched
  always_ff @(posedge clk_i) begin
    if (lane_hit_i) begin
      idx_q  <= lane_idx_i;
      data_q <= lane_data_i;
    end else if (sel) begin
      idx_q  <= MY_IDX;
      data_q <= entry_q;
    end else begin
      idx_q  <= lane_idx_i;
      data_q <= lane_data_i;
    end
  end

  assign entry_o     = entry_q;
  assign lane_hit_o  = hit_q;
  assign lane_idx_o  = idx_q;
  assign lane_data_o = data_q;

endmodule
`default_nettype wire

// File: design/rrtl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrtl_ctrl: sequencer of the run list
// Holds run count and current position, drives the cell chain through a
// search pass and an update step, and owns the result output register.
// ----------------------------------------------------------------------------
module rrtl_ctrl #(
  parameter int unsigned SLOT_COUNT = rrtl_pkg::DEFAULT_SLOT_COUNT
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  rrtl_in_if.sink                              in_i,
  rrtl_out_if.source                           out_o,
  output rrtl_pkg::cell_ctrl_t                 ctrl_o,
  output logic [$clog2(SLOT_COUNT)-1:0]        slot_key_o,
  output logic [$clog2(SLOT_COUNT)-1:0]        pos_key_o,
  output logic [$clog2(SLOT_COUNT+1)-1:0]      total_o,
  input  wire logic                            lane_hit_i,
  input  wire logic [$clog2(SLOT_COUNT)-1:0]   lane_idx_i,
  input  wire logic [$clog2(SLOT_COUNT)-1:0]   lane_data_i
);

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SLOT_COUNT - 1);
  localparam logic [CNT_W-1:0] FULL      = CNT_W'(SLOT_COUNT);
  localparam logic [CNT_W-1:0] ONE       = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO       = CNT_W'(2);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_EMIT
  } state_e;

  state_e                          state_q, state_d;
  rrtl_pkg::op_e                   op_q, op_d;
  logic [IDX_W-1:0]                slot_q, slot_d;
  logic                            in_range_q, in_range_d;
  logic                            reread_q, reread_d;
  logic [CNT_W-1:0]                cnt_q, cnt_d;
  logic [CNT_W-1:0]                total_q, total_d;
  logic [IDX_W-1:0]                cp_q, cp_d;
  rrtl_pkg::status_e               res_status_q, res_status_d;
  logic [rrtl_pkg::SLOT_W-1:0]     res_slot_q, res_slot_d;
  logic                            res_jump_q, res_jump_d;
  logic                            out_valid_q, out_valid_d;
  rrtl_pkg::status_e               out_status_q, out_status_d;
  logic [rrtl_pkg::SLOT_W-1:0]     out_slot_q, out_slot_d;
  logic                            out_jump_q, out_jump_d;
  logic [rrtl_pkg::COUNT_W-1:0]    out_count_q, out_count_d;

  logic [CNT_W-1:0]                cp_inc;
  logic [IDX_W-1:0]                tick_cp;
  logic [CNT_W-1:0]                total_m1;
  logic [IDX_W-1:0]                cp_adj;
  logic [IDX_W-1:0]                sleep_cp;

  // position after a tick, with wraparound
  assign cp_inc  = CNT_W'(cp_q) + ONE;
  assign tick_cp = (cp_inc >= total_q) ? '0 : IDX_W'(cp_inc);

  // position after removing the entry found by the lane
  assign total_m1 = total_q - ONE;
  assign cp_adj   = (lane_idx_i < cp_q) ? (cp_q - IDX_W'(1)) : cp_q;
  assign sleep_cp = (CNT_W'(cp_adj) >= total_m1) ? '0 : cp_adj;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    slot_d       = slot_q;
    in_range_d   = in_range_q;
    reread_d     = reread_q;
    cnt_d        = cnt_q;
    total_d      = total_q;
    cp_d         = cp_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_jump_d   = res_jump_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_jump_d   = out_jump_q;
    out_count_d  = out_count_q;

    ctrl_o.sel      = rrtl_pkg::SEL_FREE;
    ctrl_o.wr_mark  = 1'b0;
    ctrl_o.mark_val = rrtl_pkg::MARK_FREE;
    ctrl_o.wr_entry = 1'b0;
    ctrl_o.shift    = 1'b0;
    slot_key_o      = slot_q;
    pos_key_o       = '0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d       = rrtl_pkg::op_e'(in_i.operation);
          slot_d     = IDX_W'(in_i.task_slot);
          in_range_d = (32'(in_i.task_slot) < 32'(SLOT_COUNT));
          reread_d   = 1'b0;
          cnt_d      = '0;
          state_d    = S_SCAN;
        end
      end

      S_SCAN: begin
        if (reread_q) begin
          ctrl_o.sel = rrtl_pkg::SEL_POS;
          pos_key_o  = cp_q;
        end else begin
          unique case (op_q)
            rrtl_pkg::OP_ALLOC: ctrl_o.sel = rrtl_pkg::SEL_FREE;
            rrtl_pkg::OP_RUN:   ctrl_o.sel = rrtl_pkg::SEL_ACTIVE;
            rrtl_pkg::OP_TICK: begin
              ctrl_o.sel = rrtl_pkg::SEL_POS;
              pos_key_o  = tick_cp;
            end
            default:            ctrl_o.sel = rrtl_pkg::SEL_ENTRY;
          endcase
        end
        cnt_d = cnt_q + ONE;
        // hold until the lane word has reached the top of the chain
        if (cnt_q == LAST_STEP) begin
          state_d = S_APPLY;
        end
      end

      S_APPLY: begin
        res_status_d = rrtl_pkg::ST_DONE;
        res_slot_d   = '0;
        res_jump_d   = 1'b0;
        state_d      = S_EMIT;
        if (reread_q) begin
          res_slot_d = rrtl_pkg::SLOT_W'(lane_data_i);
          res_jump_d = 1'b1;
        end else begin
          unique case (op_q)
            rrtl_pkg::OP_ALLOC: begin
              slot_key_o = lane_idx_i;
              if (lane_hit_i) begin
                ctrl_o.wr_mark  = 1'b1;
                ctrl_o.mark_val = rrtl_pkg::MARK_SLEEPING;
                res_slot_d      = rrtl_pkg::SLOT_W'(lane_idx_i);
              end else begin
                res_status_d = rrtl_pkg::ST_FULL;
              end
            end
            rrtl_pkg::OP_RUN: begin
              pos_key_o = IDX_W'(total_q);
              if (!in_range_q) begin
                res_status_d = rrtl_pkg::ST_IGNORED;
              end else if (lane_hit_i) begin
                res_status_d = rrtl_pkg::ST_DONE;
              end else if (total_q >= FULL) begin
                res_status_d = rrtl_pkg::ST_FULL;
              end else begin
                ctrl_o.wr_mark  = 1'b1;
                ctrl_o.mark_val = rrtl_pkg::MARK_ACTIVE;
                ctrl_o.wr_entry = 1'b1;
                total_d         = total_q + ONE;
              end
            end
            rrtl_pkg::OP_TICK: begin
              if (total_q >= TWO) begin
                cp_d       = tick_cp;
                res_slot_d = rrtl_pkg::SLOT_W'(lane_data_i);
                res_jump_d = 1'b1;
              end
            end
            default: begin
              pos_key_o = lane_idx_i;
              // an active slot always sits in the list, so a hit means active
              if (!in_range_q || !lane_hit_i) begin
                res_status_d = rrtl_pkg::ST_IGNORED;
              end else begin
                ctrl_o.shift    = 1'b1;
                ctrl_o.wr_mark  = 1'b1;
                ctrl_o.mark_val = rrtl_pkg::MARK_SLEEPING;
                total_d         = total_m1;
                cp_d            = sleep_cp;
                if ((lane_idx_i == cp_q) && (total_m1 != '0)) begin
                  // current task slept: fetch the entry now under the position
                  reread_d = 1'b1;
                  cnt_d    = '0;
                  state_d  = S_SCAN;
                end
              end
            end
          endcase
        end
      end

      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          out_jump_d   = res_jump_q;
          out_count_d  = rrtl_pkg::COUNT_W'(total_q);
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= rrtl_pkg::OP_ALLOC;
      slot_q       <= '0;
      in_range_q   <= 1'b0;
      reread_q     <= 1'b0;
      cnt_q        <= '0;
      total_q      <= ONE;
      cp_q         <= '0;
      res_status_q <= rrtl_pkg::ST_DONE;
      res_slot_q   <= '0;
      res_jump_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= rrtl_pkg::ST_DONE;
      out_slot_q   <= '0;
      out_jump_q   <= 1'b0;
      out_count_q  <= '0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      slot_q       <= slot_d;
      in_range_q   <= in_range_d;
      reread_q     <= reread_d;
      cnt_q        <= cnt_d;
      total_q      <= total_d;
      cp_q         <= cp_d;
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
      res_jump_q   <= res_jump_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_slot_q   <= out_slot_d;
      out_jump_q   <= out_jump_d;
      out_count_q  <= out_count_d;
    end
  end

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.slot          = out_slot_q;
  assign out_o.jump          = out_jump_q;
  assign out_o.running_count = out_count_q;
  assign total_o             = total_q;

endmodule
`default_nettype wire

// File: design/round_robin_task_run_list.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_task_run_list: round-robin task scheduler run list
// Slot marks and run list held in a chain of cells under one sequencer.
// ----------------------------------------------------------------------------
// Each operation word (allocate, run, tick, sleep) is handled one at a time.
// A search word travels up the chain of SLOT_COUNT cells, one cell per cycle;
// the top word is then applied and the result is written to the output
// register, which waits while the previous result is still unread, and the
// next word is taken once the sequencer is idle again. A sleep of the current
// task while others remain sends a second pass up the chain to fetch the next
// task. The output register lets a new word be taken while the previous
// result waits. Reset takes effect at once, with no clearing pass.
// ----------------------------------------------------------------------------
module round_robin_task_run_list #(
  parameter int unsigned SLOT_COUNT = rrtl_pkg::DEFAULT_SLOT_COUNT
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rrtl_in_if.sink    in_i,
  rrtl_out_if.source out_o
);

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);

  rrtl_pkg::cell_ctrl_t ctrl;
  logic [IDX_W-1:0]     slot_key;
  logic [IDX_W-1:0]     pos_key;
  logic [CNT_W-1:0]     total;

  logic [IDX_W-1:0]     entry_w   [SLOT_COUNT];
  logic                 lane_hit  [SLOT_COUNT+1];
  logic [IDX_W-1:0]     lane_idx  [SLOT_COUNT+1];
  logic [IDX_W-1:0]     lane_data [SLOT_COUNT+1];

  assign lane_hit[0]  = 1'b0;
  assign lane_idx[0]  = '0;
  assign lane_data[0] = '0;

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    logic [IDX_W-1:0] next_entry;
    if (g == SLOT_COUNT - 1) begin : g_top
      assign next_entry = entry_w[g];
    end else begin : g_mid
      assign next_entry = entry_w[g+1];
    end

    rrtl_cell #(
      .SLOT_COUNT (SLOT_COUNT),
      .CELL_INDEX (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .slot_key_i   (slot_key),
      .pos_key_i    (pos_key),
      .total_i      (total),
      .next_entry_i (next_entry),
      .entry_o      (entry_w[g]),
      .lane_hit_i   (lane_hit[g]),
      .lane_idx_i   (lane_idx[g]),
      .lane_data_i  (lane_data[g]),
      .lane_hit_o   (lane_hit[g+1]),
      .lane_idx_o   (lane_idx[g+1]),
      .lane_data_o  (lane_data[g+1])
    );
  end

  rrtl_ctrl #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .ctrl_o      (ctrl),
    .slot_key_o  (slot_key),
    .pos_key_o   (pos_key),
    .total_o     (total),
    .lane_hit_i  (lane_hit[SLOT_COUNT]),
    .lane_idx_i  (lane_idx[SLOT_COUNT]),
    .lane_data_i (lane_data[SLOT_COUNT])
  );

  // run count never exceeds the number of slots
  a_total_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(total) <= SLOT_COUNT)
    else $error("run count above slot count");

  // append and gap closing never share a cycle
  a_one_list_edit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.shift && ctrl.wr_entry))
    else $error("append and shift in the same cycle");

  // the chain is only written while no new word can be taken
  a_write_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.wr_mark || ctrl.wr_entry || ctrl.shift) |-> !in_i.ready)
    else $error("chain written while idle");

  // a list edit changes the run count in the next cycle
  a_edit_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.wr_entry || ctrl.shift) |=> (total != $past(total)))
    else $error("list edited without run count change");

endmodule
`default_nettype wire
